// File: sv/q4dq_pkg.sv
// Package for the 4-bit dequantize dot product block.
// Holds the queue entry type and the f32 arithmetic helper functions.
// No dependencies.
`default_nettype none

package q4dq_pkg;

    localparam logic [30:0] SanitizeLimit = 31'h42C8_0000;  // 100.0 as f32 magnitude
    localparam logic [31:0] DefaultNan    = 32'hFFC0_0000;
    localparam logic [31:0] QuietBit      = 32'h0040_0000;
    localparam logic [3:0]  NibbleMask    = 4'hF;

    // One element as it travels from the front end to the arithmetic back end.
    typedef struct packed {
        logic        el_valid;
        logic [31:0] weight;
        logic [31:0] scale;
        logic [31:0] zero;
        logic [31:0] act;
        logic        last;
    } q4dq_entry_t;

    // Operation result before normalization and rounding.
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [11:0] be0;
        logic [48:0]        mag;
    } q4dq_pend_t;

    // Two's complement nibble to f32; every value is exact.
    function automatic logic [31:0] nibble_to_f32(input logic [3:0] q);
        logic [3:0]  mag;
        logic [30:0] body;
        mag = q[3] ? 4'(5'd16 - {1'b0, q}) : q;
        unique case (mag)
            4'd0:    body = 31'h0000_0000;
            4'd1:    body = 31'h3F80_0000;
            4'd2:    body = 31'h4000_0000;
            4'd3:    body = 31'h4040_0000;
            4'd4:    body = 31'h4080_0000;
            4'd5:    body = 31'h40A0_0000;
            4'd6:    body = 31'h40C0_0000;
            4'd7:    body = 31'h40E0_0000;
            4'd8:    body = 31'h4100_0000;
            default: body = 31'h0000_0000;
        endcase
        return {q[3], body};
    endfunction

    // Widen bf16 to f32 and force values of magnitude 100 or more, and NaN, to +0.
    function automatic logic [31:0] widen_clean(input logic [15:0] bf);
        logic [31:0] x;
        x = {bf, 16'h0000};
        return (x[30:0] < SanitizeLimit) ? x : 32'h0000_0000;
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // Multiply: special cases, or the exact 48-bit mantissa product.
    function automatic q4dq_pend_t mul_pre(input logic [31:0] a, input logic [31:0] b);
        q4dq_pend_t p;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [23:0] ma;
        logic [23:0] mb;
        p = '0;
        p.sign = a[31] ^ b[31];
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (is_nan(a)) begin
            p.special = 1'b1;
            p.spec_val = a | QuietBit;
        end else if (is_nan(b)) begin
            p.special = 1'b1;
            p.spec_val = b | QuietBit;
        end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
            p.special = 1'b1;
            p.spec_val = DefaultNan;
        end else if (is_inf(a) || is_inf(b)) begin
            p.special = 1'b1;
            p.spec_val = {p.sign, 8'hFF, 23'd0};
        end else begin
            p.mag = {1'b0, 48'(ma) * 48'(mb)};
            p.be0 = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd125;
        end
        return p;
    endfunction

    // Add: special cases, or the aligned sum with a sticky bit.
    function automatic q4dq_pend_t add_pre(input logic [31:0] a, input logic [31:0] b);
        q4dq_pend_t p;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [48:0] big;
        logic [48:0] small_v;
        logic [48:0] shifted;
        logic        lost;
        logic [48:0] r;
        p = '0;
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d = ex - ey;
        big     = {1'b0, x[30:23] != 8'd0, x[22:0], 24'd0};
        small_v = {1'b0, y[30:23] != 8'd0, y[22:0], 24'd0};
        if (d >= 8'd49) begin
            shifted = '0;
            lost = |small_v;
        end else begin
            shifted = small_v >> d;
            lost = (shifted << d) != small_v;
        end
        if (x[31] == y[31]) begin
            r = big + (shifted | {48'd0, lost});
        end else begin
            r = big - (shifted | {48'd0, lost});
        end
        if (is_nan(a)) begin
            p.special = 1'b1;
            p.spec_val = a | QuietBit;
        end else if (is_nan(b)) begin
            p.special = 1'b1;
            p.spec_val = b | QuietBit;
        end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
            p.special = 1'b1;
            p.spec_val = DefaultNan;
        end else if (is_inf(a)) begin
            p.special = 1'b1;
            p.spec_val = a;
        end else if (is_inf(b)) begin
            p.special = 1'b1;
            p.spec_val = b;
        end else begin
            p.mag = r;
            p.sign = (r == 49'd0) ? (a[31] & b[31]) : x[31];
            p.be0 = $signed({4'd0, ex}) + 12'sd1;
        end
        return p;
    endfunction

    // Normalize, round to nearest even and pack.
    function automatic logic [31:0] round_pack(input q4dq_pend_t p);
        logic [5:0]         lz;
        logic [48:0]        mn;
        logic signed [11:0] be;
        logic [11:0]        sh;
        logic               stk;
        logic [48:0]        tmp;
        logic [8:0]         benc;
        logic [23:0]        mant;
        logic               g;
        logic               s;
        logic [24:0]        rnd;
        logic [33:0]        enc;
        logic [31:0]        res;
        lz = 6'd0;
        for (int i = 0; i < 49; i++) begin
            if (p.mag[i]) begin
                lz = 6'(48 - i);
            end
        end
        mn = p.mag << lz;
        be = p.be0 - $signed({6'd0, lz});
        stk = 1'b0;
        benc = 9'd0;
        if (be < 12'sd1) begin
            sh = 12'(12'sd1 - be);
            if (sh >= 12'd49) begin
                stk = |mn;
                mn = '0;
            end else begin
                tmp = mn >> sh;
                stk = (tmp << sh) != mn;
                mn = tmp;
            end
        end else begin
            benc = 9'(be - 12'sd1);
        end
        mant = mn[48:25];
        g = mn[24];
        s = (|mn[23:0]) | stk;
        rnd = {1'b0, mant} + {24'd0, g & (s | mant[0])};
        enc = {2'd0, benc, 23'd0} + {9'd0, rnd};
        if (p.special) begin
            res = p.spec_val;
        end else if (p.mag == 49'd0) begin
            res = {p.sign, 31'd0};
        end else if (enc >= {3'd0, 8'hFF, 23'd0}) begin
            res = {p.sign, 8'hFF, 23'd0};
        end else begin
            res = {p.sign, enc[30:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/q4dq_front.sv
// Front end: holds the expert count register, checks the expert id and
// decodes the nibble, scale and zero point into a queue entry. Uses q4dq_pkg.
`default_nettype none

module q4dq_front
    import q4dq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_enable,
    input  wire logic [8:0]        cfg_write_data,
    input  wire logic signed [8:0] expert_id,
    input  wire logic [7:0]        packed_byte,
    input  wire logic              high_nibble,
    input  wire logic [15:0]       scale_bits,
    input  wire logic [15:0]       zero_bits,
    input  wire logic [31:0]       activation_bits,
    input  wire logic              last,
    output q4dq_entry_t            entry
);

    logic [8:0] expert_count_reg;
    logic [3:0] nib;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expert_count_reg <= 9'd1;
        end
        else if (cfg_write_enable)
        begin
            expert_count_reg <= cfg_write_data;
        end
    end

    assign nib = high_nibble ? packed_byte[7:4] : (packed_byte[3:0] & NibbleMask);

    always_comb
    begin
        entry.el_valid = !expert_id[8] && ({1'b0, expert_id[7:0]} < expert_count_reg);
        entry.weight   = nibble_to_f32(nib);
        entry.scale    = widen_clean(scale_bits);
        entry.zero     = widen_clean(zero_bits);
        entry.act      = activation_bits;
        entry.last     = last;
    end

endmodule

`default_nettype wire

// File: sv/q4dq_fifo.sv
// Two-entry queue between the front end and the arithmetic back end.
// Uses q4dq_pkg for the entry type.
`default_nettype none

module q4dq_fifo
    import q4dq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire q4dq_entry_t push_data,
    input  wire logic  pop,
    output logic       full,
    output logic       empty,
    output q4dq_entry_t head
);

    q4dq_entry_t mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

endmodule

`default_nettype wire

// File: sv/q4dq_back.sv
// Back end: runs the two multiplies and two adds of each element through one
// shared operation stage and one rounding stage, and holds the result word.
// Uses q4dq_pkg.
`default_nettype none

module q4dq_back
    import q4dq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  empty,
    input  wire q4dq_entry_t head,
    output logic       pop,
    output logic       result_valid,
    input  wire logic  result_stall,
    output logic [31:0] sum_bits,
    output logic       expert_invalid
);

    typedef enum logic [1:0] {S_IDLE, S_OP, S_RND, S_FIN} state_t;

    state_t      state_reg;
    q4dq_entry_t cur_reg;
    logic [1:0]  step_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    q4dq_pend_t  pend_reg;
    logic [31:0] acc_reg;
    logic        inv_seen_reg;
    logic        out_valid_reg;
    logic [31:0] sum_reg;
    logic        inv_out_reg;
    logic [31:0] rounded;
    logic        out_free;
    logic        out_load;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign rounded  = round_pack(pend_reg);
    assign out_free = !out_valid_reg || !result_stall;
    // A new result word enters the output register this cycle.
    assign out_load = (state_reg == S_FIN) && cur_reg.last && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            acc_reg       <= 32'd0;
            inv_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            a_reg         <= 32'd0;
            b_reg         <= 32'd0;
            pend_reg      <= '0;
            sum_reg       <= 32'd0;
            inv_out_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        cur_reg  <= head;
                        a_reg    <= head.weight;
                        b_reg    <= head.scale;
                        step_reg <= 2'd0;
                        if (head.el_valid)
                        begin
                            state_reg <= S_OP;
                        end
                        else
                        begin
                            inv_seen_reg <= 1'b1;
                            state_reg    <= S_FIN;
                        end
                    end
                end
                S_OP:
                begin
                    pend_reg  <= step_reg[0] ? add_pre(a_reg, b_reg) : mul_pre(a_reg, b_reg);
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    step_reg  <= step_reg + 2'd1;
                    state_reg <= (step_reg == 2'd3) ? S_FIN : S_OP;
                    unique case (step_reg)
                        2'd0:
                        begin
                            a_reg <= rounded;
                            b_reg <= cur_reg.zero;
                        end
                        2'd1:
                        begin
                            a_reg <= rounded;
                            b_reg <= cur_reg.act;
                        end
                        2'd2:
                        begin
                            a_reg <= acc_reg;
                            b_reg <= rounded;
                        end
                        default:
                        begin
                            acc_reg <= rounded;
                        end
                    endcase
                end
                S_FIN:
                begin
                    if (!cur_reg.last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= inv_seen_reg ? 32'd0 : acc_reg;
                        inv_out_reg   <= inv_seen_reg;
                        acc_reg       <= 32'd0;
                        inv_seen_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = out_valid_reg;
    assign sum_bits       = sum_reg;
    assign expert_invalid = inv_out_reg;

endmodule

`default_nettype wire

// File: sv/q4_dequant_dot_product.sv
// Top level of the 4-bit dequantize dot product block.
// Instantiates q4dq_front, q4dq_fifo and q4dq_back; uses q4dq_pkg.
//
// Usage: each input word is one element of a dot product. It carries a packed
// weight byte with a nibble select, bf16 scale and zero point, an f32
// activation, an expert id and a last flag. A word is taken on a rising edge
// with item_valid high and item_stall low. The front end checks the id against
// the expert count register, decodes the weight and sanitizes scale and zero
// point, then writes the element into a two-entry queue.
// The back end computes (weight*scale + zero)*activation and adds it to an
// f32 accumulator, rounding each step to nearest even. One shared operation
// stage and one rounding stage are reused for all four steps, so the back end
// takes the next element from the queue only when done with the last one; an
// element with an invalid id skips the steps. On the last element the sum (or
// zero, with expert_invalid set, if any id was out of range) goes into the
// result register once it is free. The result word is held while result_stall
// is high; the queue keeps taking words until it is full. Reset clears the
// accumulator, the queue and the result register and sets the expert
// count to 1. The user must write it through cfg_write_enable and
// cfg_write_data only while the block is idle; the block does not enforce this.
`default_nettype none

module q4_dequant_dot_product
    import q4dq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_enable,
    input  wire logic [8:0]        cfg_write_data,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic signed [8:0] expert_id,
    input  wire logic [7:0]        packed_byte,
    input  wire logic              high_nibble,
    input  wire logic [15:0]       scale_bits,
    input  wire logic [15:0]       zero_bits,
    input  wire logic [31:0]       activation_bits,
    input  wire logic              last,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [31:0]            sum_bits,
    output logic                   expert_invalid
);

    q4dq_entry_t entry;
    q4dq_entry_t head;
    logic        full;
    logic        empty;
    logic        pop;
    logic        push;

    // The queue full flag is the only source of input back pressure.
    assign item_stall = full;
    assign push       = item_valid && !full;

    q4dq_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .expert_id        (expert_id),
        .packed_byte      (packed_byte),
        .high_nibble      (high_nibble),
        .scale_bits       (scale_bits),
        .zero_bits        (zero_bits),
        .activation_bits  (activation_bits),
        .last             (last),
        .entry            (entry)
    );

    q4dq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    q4dq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sum_bits       (sum_bits),
        .expert_invalid (expert_invalid)
    );

endmodule

`default_nettype wire
